### design/stepper_microstep_positioner_assert.svh
// Assertion macros for the stepper microstep positioner.
// Included by the top level; needs no package.
`ifndef STEPPER_MICROSTEP_POSITIONER_ASSERT_SVH
`define STEPPER_MICROSTEP_POSITIONER_ASSERT_SVH
`ifndef SYNTHESIS
`define SMP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define SMP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SMP_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SMP_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

### design/stp_pkg.sv
// Package for the stepper microstep positioner: widths, command and register
// codes, coil types and the level table. No dependencies.
`default_nettype none
package stp_pkg;
	localparam int SUBSTEP_BITS = 4;
	localparam int TIMER_WIDTH = 20;
	localparam int POS_W = 32;
	localparam int SIZE_W = 8;
	localparam int PERIOD_W = 20;
	localparam int LEVEL_W = 8;
	localparam int CFG_DATA_W = 20;

	localparam logic [2:0] MODE_FWD = 3'b001;
	localparam logic [2:0] MODE_REV = 3'b010;
	localparam logic [2:0] MODE_PWR = 3'b100;
	localparam logic [2:0] MODE_OFF = 3'b000;

	localparam logic [3:0] COIL_A_PATTERN = 4'b0011;
	localparam logic [3:0] COIL_B_PATTERN = 4'b1001;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_MOVE_TO  = 3'd1,
		CMD_MOVE_BY  = 3'd2,
		CMD_RUN_FWD  = 3'd3,
		CMD_RUN_REV  = 3'd4,
		CMD_HOLD     = 3'd5,
		CMD_RELEASE  = 3'd6
	} cmd_t;

	typedef enum logic [0:0] {
		REG_SUBSTEP_SIZE = 1'b0,
		REG_STEP_PERIOD  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic               a_plus;
		logic               a_minus;
		logic [LEVEL_W-1:0] a_drive;
		logic               b_plus;
		logic               b_minus;
		logic [LEVEL_W-1:0] b_drive;
	} coil_t;

	localparam logic [LEVEL_W-1:0] LEVEL_TABLE [17] = '{
		8'h00, 8'h19, 8'h32, 8'h4a, 8'h62, 8'h78, 8'h8e, 8'ha2,
		8'hb4, 8'hc5, 8'hd4, 8'he1, 8'hec, 8'hf4, 8'hfa, 8'hfe, 8'hff};

	function automatic logic [LEVEL_W-1:0] level_lookup(input logic [SUBSTEP_BITS:0] idx);
		logic [SUBSTEP_BITS+4:0] scaled;
		logic [4:0]              k;
		scaled = {idx, 4'b0000} >> SUBSTEP_BITS;
		if (scaled > (SUBSTEP_BITS+5)'(16)) begin
			k = 5'd16;
		end else begin
			k = scaled[4:0];
		end
		return LEVEL_TABLE[k];
	endfunction
endpackage
`default_nettype wire

### design/stp_drive.sv
// Coil drive decode: quadrant and substep of a position to polarities and levels.
// Uses stp_pkg.
`default_nettype none
module stp_drive (
	input  wire logic [stp_pkg::POS_W-1:0] position,
	output stp_pkg::coil_t                 coil
);
	import stp_pkg::*;

	logic [1:0]              quad;
	logic [SUBSTEP_BITS-1:0] sub;
	logic [SUBSTEP_BITS:0]   sub_up;
	logic [SUBSTEP_BITS:0]   sub_dn;
	logic                    a1;
	logic                    b1;

	assign quad   = position[SUBSTEP_BITS+1:SUBSTEP_BITS];
	assign sub    = position[SUBSTEP_BITS-1:0];
	assign sub_up = {1'b0, sub};
	assign sub_dn = (SUBSTEP_BITS+1)'(1 << SUBSTEP_BITS) - {1'b0, sub};
	assign a1     = COIL_A_PATTERN[quad];
	assign b1     = COIL_B_PATTERN[quad];

	always_comb begin
		coil.a_plus  = a1;
		coil.a_minus = ~a1;
		coil.b_plus  = b1;
		coil.b_minus = ~b1;
		if (!quad[0]) begin
			coil.a_drive = level_lookup(sub_up);
			coil.b_drive = level_lookup(sub_dn);
		end else begin
			coil.a_drive = level_lookup(sub_dn);
			coil.b_drive = level_lookup(sub_up);
		end
	end
endmodule
`default_nettype wire

### design/stp_core.sv
// Positioner state and next-state logic: goal, mode, timer, step and coil state.
// Uses stp_pkg and stp_drive.
`default_nettype none
module stp_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire logic [2:0]                    command,
	input  wire logic [stp_pkg::POS_W-1:0]     value,
	input  wire logic [stp_pkg::SIZE_W-1:0]    substep_size,
	input  wire logic [stp_pkg::PERIOD_W-1:0]  step_period,
	output logic      [stp_pkg::POS_W-1:0]     position,
	output stp_pkg::coil_t                     coil,
	output logic                               powered
);
	import stp_pkg::*;

	logic [POS_W-1:0]       pos_q, pos_d;
	logic [POS_W-1:0]       goal_q, goal_d;
	logic [2:0]             mode_q, mode_d;
	logic                   en_q, en_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	coil_t                  coil_q, coil_d;

	logic [TIMER_WIDTH-1:0] timer_inc;
	logic                   due;
	logic [POS_W-1:0]       step;
	logic [POS_W-1:0]       goal_run;
	logic [POS_W-1:0]       pos_fwd;
	logic [POS_W-1:0]       pos_new;
	logic [POS_W-1:0]       drive_pos;
	coil_t                  coil_new;

	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + TIMER_WIDTH'(1);
	assign due       = 32'(timer_inc) >= 32'(step_period);
	assign step      = POS_W'(substep_size);

	always_comb begin
		goal_run = goal_q;
		if (pos_q == goal_q) begin
			if ((mode_q & MODE_FWD) != MODE_OFF) goal_run = pos_q + step;
			if ((mode_q & MODE_REV) != MODE_OFF) goal_run = pos_q - step;
		end
		pos_fwd = ($signed(pos_q) < $signed(goal_run)) ? pos_q + step : pos_q;
		pos_new = ($signed(goal_run) < $signed(pos_fwd)) ? pos_fwd - step : pos_fwd;
	end

	assign drive_pos = en_q ? pos_new : pos_q;

	stp_drive u_drive (
		.position (drive_pos),
		.coil     (coil_new)
	);

	always_comb begin
		pos_d   = pos_q;
		goal_d  = goal_q;
		mode_d  = mode_q;
		en_d    = en_q;
		timer_d = timer_q;
		coil_d  = coil_q;
		case (command)
			CMD_TICK: begin
				timer_d = timer_inc;
				if ((mode_q & MODE_PWR) != MODE_OFF) begin
					if (!en_q) begin
						coil_d  = coil_new;
						timer_d = '0;
						en_d    = 1'b1;
					end else if (due) begin
						goal_d  = goal_run;
						pos_d   = pos_new;
						coil_d  = coil_new;
						timer_d = '0;
					end
				end else if (en_q) begin
					coil_d = '0;
					en_d   = 1'b0;
				end
			end
			CMD_MOVE_TO: begin
				goal_d = value;
				mode_d = MODE_PWR;
			end
			CMD_MOVE_BY: begin
				goal_d = goal_q + value;
				mode_d = MODE_PWR;
			end
			CMD_RUN_FWD: begin
				goal_d = pos_q;
				mode_d = MODE_FWD | MODE_PWR;
			end
			CMD_RUN_REV: begin
				goal_d = pos_q;
				mode_d = MODE_REV | MODE_PWR;
			end
			CMD_HOLD: begin
				goal_d = pos_q;
				mode_d = MODE_PWR;
			end
			CMD_RELEASE: begin
				mode_d = MODE_OFF;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			goal_q  <= '0;
			mode_q  <= MODE_OFF;
			en_q    <= 1'b0;
			timer_q <= '0;
			coil_q  <= '0;
		end else if (fire) begin
			pos_q   <= pos_d;
			goal_q  <= goal_d;
			mode_q  <= mode_d;
			en_q    <= en_d;
			timer_q <= timer_d;
			coil_q  <= coil_d;
		end
	end

	assign position = pos_q;
	assign coil     = coil_q;
	assign powered  = en_q;
endmodule
`default_nettype wire

### design/stepper_microstep_positioner.sv
// Top level of the stepper microstep positioner: request register, configuration
// registers and result handshake. Uses stp_pkg, stp_core and the assertion header.
//
//   Channel  Signals                              Direction
//   in       in_valid, in_stall, command, value   request in
//   out      out_valid, out_stall, position,      result out
//            a_plus/a_minus/a_drive,
//            b_plus/b_minus/b_drive, powered
//   cfg      cfg_wr_en, cfg_index, cfg_data       register write in
//
// One request per cycle unless stalled; its result follows the request register.
// The state registers are the result register, so a request updates them only
// when the previous result has been taken or is being taken.
// Reset clears all but the request payload; step size reads 1, step period 1000.
// A stalled result stops the request register, which then stalls the input.
`default_nettype none
`include "stepper_microstep_positioner_assert.svh"
module stepper_microstep_positioner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [2:0]                     command,
	input  wire logic signed [31:0]             value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [31:0]                  position,
	output logic                                a_plus,
	output logic                                a_minus,
	output logic [7:0]                          a_drive,
	output logic                                b_plus,
	output logic                                b_minus,
	output logic [7:0]                          b_drive,
	output logic                                powered,
	input  wire logic                           cfg_wr_en,
	input  wire logic [0:0]                     cfg_index,
	input  wire logic [stp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stp_pkg::*;

	logic                req_valid_s1;
	logic [2:0]          cmd_s1;
	logic [POS_W-1:0]    value_s1;
	logic                out_valid_q;
	logic                advance;
	logic                fire;
	logic [SIZE_W-1:0]   substep_size_q;
	logic [PERIOD_W-1:0] step_period_q;
	logic [POS_W-1:0]    pos_w;
	coil_t               coil_w;
	logic                powered_w;
	logic                coils_off;
	logic                polarity_ok;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = req_valid_s1 && advance;
	assign in_stall = req_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			req_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1   <= command;
			value_s1 <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			substep_size_q <= SIZE_W'(1);
			step_period_q  <= PERIOD_W'(1000);
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_SUBSTEP_SIZE: substep_size_q <= cfg_data[SIZE_W-1:0];
				REG_STEP_PERIOD:  step_period_q  <= cfg_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	stp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.command      (cmd_s1),
		.value        (value_s1),
		.substep_size (substep_size_q),
		.step_period  (step_period_q),
		.position     (pos_w),
		.coil         (coil_w),
		.powered      (powered_w)
	);

	assign out_valid = out_valid_q;
	assign position  = $signed(pos_w);
	assign a_plus    = coil_w.a_plus;
	assign a_minus   = coil_w.a_minus;
	assign a_drive   = coil_w.a_drive;
	assign b_plus    = coil_w.b_plus;
	assign b_minus   = coil_w.b_minus;
	assign b_drive   = coil_w.b_drive;
	assign powered   = powered_w;

	assign coils_off   = (coil_w == '0);
	assign polarity_ok = (a_plus != a_minus) && (b_plus != b_minus);

	`SMP_ASSERT_IMP(a_off_coils_quiet, clk, arst_n, out_valid && !powered, coils_off)
	`SMP_ASSERT_IMP(a_on_polarity, clk, arst_n, out_valid && powered, polarity_ok)
	`SMP_ASSERT_IMP(a_stall_needs_req, clk, arst_n, in_stall, req_valid_s1 && out_valid_q)
	`SMP_ASSERT_NEXT(a_fire_shows_result, clk, arst_n, fire, out_valid)
endmodule
`default_nettype wire
